>>> rtl/assert_macros.svh
// assertion macros used by the decoder sequencing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/icns_pkg.sv
// types, constants and command structs of the plane decoder
package icns_pkg;

  localparam int unsigned MAX_PIXELS  = 1048576;
  localparam int unsigned WORD_BYTES  = 8;
  localparam int unsigned FILL_W      = 21;
  localparam int unsigned PIX_W       = 20;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned RUN_W       = 8;
  localparam int unsigned PLANE_CNT_W = 3;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [RUN_W-1:0]       REP_BIAS    = 8'd125;
  localparam logic [FILL_W-1:0]      PIXEL_RESET = 21'd1024;
  localparam logic [PLANE_CNT_W-1:0] PLANES_RGB  = 3'd3;
  localparam logic [PLANE_CNT_W-1:0] PLANES_ARGB = 3'd4;

  typedef enum logic [0:0] {
    REG_PIXEL_COUNT = 1'b0,
    REG_PLANE_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_CODE    = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_STOP    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    STAT_DATA  = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_TRUNC = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_LIT   = 2'd0,
    KIND_REP   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_TRUNC = 2'd3
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_REPEAT = 2'd1,
    ST_DONE   = 2'd2,
    ST_TRUNC  = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       rgba_lane;
    logic [PIX_W-1:0] first_pixel;
    logic [63:0]      packed_bytes;
    logic [CNT_W-1:0] byte_count;
    logic [1:0]       status;
    logic             end_of_run;
  } out_item_t;

  typedef struct packed {
    logic [FILL_W-1:0]      pixel_count;
    logic [PLANE_CNT_W-1:0] plane_count;
  } cfg_t;

  typedef struct packed {
    logic      load_item;
    logic      step_code;
    logic      step_lit;
    logic      rep_start;
    logic      rep_word;
    logic      end_plane;
    logic      stop;
    logic      out_load;
    out_kind_e out_kind;
    logic      out_last;
  } dp_cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   lit_room;
    logic   lit_end;
    logic   lit_full;
    logic   take_zero;
    logic   rep_last;
    logic   rep_full;
    logic   last_plane;
    logic   final_item;
  } dp_stat_t;

endpackage

>>> rtl/icns_cfg.sv
// configuration register file behind the apb port
module icns_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [icns_pkg::PADDR_W-1:0]  paddr,
  input  logic [icns_pkg::DATA_W-1:0]   pwdata,
  output logic [icns_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output icns_pkg::cfg_t                cfg_o
);

  logic [icns_pkg::FILL_W-1:0]      pixel_count_q, pixel_count_d;
  logic [icns_pkg::PLANE_CNT_W-1:0] plane_count_q, plane_count_d;
  icns_pkg::reg_idx_e               idx;
  logic                             wr;

  assign idx    = icns_pkg::reg_idx_e'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    pixel_count_d = pixel_count_q;
    plane_count_d = plane_count_q;
    prdata        = '0;
    case (idx)
      icns_pkg::REG_PIXEL_COUNT: begin
        prdata = icns_pkg::DATA_W'(pixel_count_q);
        if (wr) begin
          pixel_count_d = pwdata[icns_pkg::FILL_W-1:0];
        end
      end
      icns_pkg::REG_PLANE_COUNT: begin
        prdata = icns_pkg::DATA_W'(plane_count_q);
        if (wr) begin
          plane_count_d = pwdata[icns_pkg::PLANE_CNT_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= icns_pkg::PIXEL_RESET;
      plane_count_q <= icns_pkg::PLANES_ARGB;
    end else begin
      pixel_count_q <= pixel_count_d;
      plane_count_q <= plane_count_d;
    end
  end

  assign cfg_o.pixel_count = pixel_count_q;
  assign cfg_o.plane_count = plane_count_q;

endmodule

>>> rtl/icns_dpath.sv
// decode state, run counters and output payload register
module icns_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icns_pkg::cfg_t     cfg_i,
  input  icns_pkg::in_item_t in_item_i,
  input  icns_pkg::dp_cmd_t  cmd_i,
  output icns_pkg::dp_stat_t stat_o,
  output icns_pkg::out_item_t out_item_o
);

  localparam int unsigned FW = icns_pkg::FILL_W;
  localparam int unsigned RW = icns_pkg::RUN_W;

  icns_pkg::in_item_t  itm_q;
  icns_pkg::out_item_t out_q, out_d;
  icns_pkg::phase_e    phase_q, phase_d, phase_eff;
  logic [1:0]          plane_q, plane_d, plane_eff, lane;
  logic [FW-1:0]       fill_q, fill_d, fill_eff, fill_base, fill_lit, fill_rep;
  logic [FW-1:0]       size, room;
  logic [RW-1:0]       lit_q, lit_d, lit_eff;
  logic [RW-1:0]       rep_q, rep_d, take_q, take_d, take_start;
  logic [icns_pkg::CNT_W-1:0]       cnt;
  logic [icns_pkg::PLANE_CNT_W-1:0] planes;
  logic [63:0]         rep_bytes;
  logic                first, lit_room, last_plane, wr;

  // effective size and plane count
  always_comb begin
    if (cfg_i.pixel_count == '0) begin
      size = FW'(1);
    end else if (cfg_i.pixel_count > FW'(icns_pkg::MAX_PIXELS)) begin
      size = FW'(icns_pkg::MAX_PIXELS);
    end else begin
      size = cfg_i.pixel_count;
    end
  end

  assign planes = (cfg_i.plane_count == icns_pkg::PLANES_RGB) ? icns_pkg::PLANES_RGB
                                                              : icns_pkg::PLANES_ARGB;
  assign lane   = (planes == icns_pkg::PLANES_ARGB) ? plane_q + 2'd3 : plane_q;

  // state as seen by the held item, a new decode clears it
  assign first     = itm_q.first_byte;
  assign plane_eff = first ? 2'd0 : plane_q;
  assign fill_eff  = first ? '0 : fill_q;
  assign phase_eff = first ? icns_pkg::PH_CODE : phase_q;
  assign lit_eff   = first ? '0 : lit_q;

  assign lit_room   = fill_eff < size;
  assign room       = lit_room ? size - fill_eff : '0;
  assign take_start = (FW'(rep_q) < room) ? rep_q : room[RW-1:0];
  assign cnt        = (take_q < RW'(icns_pkg::WORD_BYTES)) ? take_q[icns_pkg::CNT_W-1:0]
                                                           : icns_pkg::CNT_W'(icns_pkg::WORD_BYTES);
  assign fill_lit   = fill_eff + FW'(lit_room);
  assign fill_rep   = fill_q + FW'(cnt);
  assign last_plane = ({1'b0, plane_eff} + 3'd1) >= planes;

  always_comb begin
    rep_bytes = '0;
    for (int j = 0; j < int'(icns_pkg::WORD_BYTES); j++) begin
      if (j < int'(cnt)) begin
        rep_bytes[8*j +: 8] = itm_q.data_byte;
      end
    end
  end

  assign stat_o.phase      = phase_eff;
  assign stat_o.lit_room   = lit_room;
  assign stat_o.lit_end    = lit_eff <= RW'(1);
  assign stat_o.lit_full   = fill_lit >= size;
  assign stat_o.take_zero  = take_start == '0;
  assign stat_o.rep_last   = take_q <= RW'(icns_pkg::WORD_BYTES);
  assign stat_o.rep_full   = fill_rep >= size;
  assign stat_o.last_plane = last_plane;
  assign stat_o.final_item = itm_q.final_byte;

  assign wr = cmd_i.step_code || cmd_i.step_lit || cmd_i.rep_start || cmd_i.rep_word ||
              cmd_i.stop || cmd_i.end_plane;

  always_comb begin
    fill_base = cmd_i.step_lit ? fill_lit : (cmd_i.rep_word ? fill_rep : fill_eff);
    fill_d    = cmd_i.end_plane ? '0 : fill_base;
    plane_d   = plane_eff;
    if (cmd_i.end_plane) begin
      plane_d = last_plane ? 2'd0 : plane_eff + 2'd1;
    end

    phase_d = phase_eff;
    if (cmd_i.step_code) begin
      phase_d = itm_q.data_byte[7] ? icns_pkg::PH_REPEAT : icns_pkg::PH_LITERAL;
    end
    if (cmd_i.step_lit && stat_o.lit_end) begin
      phase_d = icns_pkg::PH_CODE;
    end
    if ((cmd_i.rep_start && stat_o.take_zero) || (cmd_i.rep_word && stat_o.rep_last)) begin
      phase_d = icns_pkg::PH_CODE;
    end
    if ((cmd_i.end_plane && last_plane) || cmd_i.stop) begin
      phase_d = icns_pkg::PH_STOP;
    end

    lit_d = lit_eff;
    rep_d = first ? '0 : rep_q;
    if (cmd_i.step_code) begin
      if (itm_q.data_byte[7]) begin
        rep_d = itm_q.data_byte - icns_pkg::REP_BIAS;
      end else begin
        lit_d = itm_q.data_byte + RW'(1);
      end
    end
    if (cmd_i.step_lit && (lit_eff != '0)) begin
      lit_d = lit_eff - RW'(1);
    end

    take_d = take_q;
    if (cmd_i.rep_start) begin
      take_d = take_start;
    end else if (cmd_i.rep_word) begin
      take_d = take_q - RW'(cnt);
    end
  end

  always_comb begin
    out_d            = '0;
    out_d.end_of_run = cmd_i.out_last;
    case (cmd_i.out_kind)
      icns_pkg::KIND_LIT: begin
        out_d.rgba_lane    = lane;
        out_d.first_pixel  = fill_eff[icns_pkg::PIX_W-1:0];
        out_d.packed_bytes = 64'(itm_q.data_byte);
        out_d.byte_count   = icns_pkg::CNT_W'(1);
        out_d.status       = icns_pkg::STAT_DATA;
      end
      icns_pkg::KIND_REP: begin
        out_d.rgba_lane    = lane;
        out_d.first_pixel  = fill_q[icns_pkg::PIX_W-1:0];
        out_d.packed_bytes = rep_bytes;
        out_d.byte_count   = cnt;
        out_d.status       = icns_pkg::STAT_DATA;
      end
      icns_pkg::KIND_DONE: begin
        out_d.status = icns_pkg::STAT_DONE;
      end
      icns_pkg::KIND_TRUNC: begin
        out_d.status = icns_pkg::STAT_TRUNC;
      end
      default: begin
        out_d.status = icns_pkg::STAT_DATA;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
      fill_q  <= '0;
      phase_q <= icns_pkg::PH_CODE;
      lit_q   <= '0;
      rep_q   <= '0;
      take_q  <= '0;
    end else if (wr) begin
      plane_q <= plane_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      lit_q   <= lit_d;
      rep_q   <= rep_d;
      take_q  <= take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      itm_q <= in_item_i;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

>>> rtl/icns_ctrl.sv
// sequencing state machine and handshake control of the decoder
`include "assert_macros.svh"

module icns_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  icns_pkg::dp_stat_t stat_i,
  output icns_pkg::dp_cmd_t  cmd_o
);

  icns_pkg::state_e  state_q, state_d;
  icns_pkg::dp_cmd_t cmd;
  logic              itm_v_q, itm_v_d, ov_q, ov_d;
  logic              out_free, consume, lit_close, rep_close, done, trunc;

  assign out_free  = !ov_q || !out_stall_i;
  assign lit_close = stat_i.lit_end && stat_i.lit_full;
  assign rep_close = stat_i.rep_last && stat_i.rep_full;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    consume = 1'b0;
    done    = 1'b0;
    trunc   = 1'b0;
    case (state_q)
      icns_pkg::ST_RUN: begin
        if (itm_v_q) begin
          case (stat_i.phase)
            icns_pkg::PH_STOP: begin
              consume = 1'b1;
            end
            icns_pkg::PH_CODE: begin
              if (!stat_i.final_item) begin
                cmd.step_code = 1'b1;
                consume       = 1'b1;
              end else if (out_free) begin
                cmd.step_code = 1'b1;
                cmd.stop      = 1'b1;
                cmd.out_load  = 1'b1;
                cmd.out_kind  = icns_pkg::KIND_TRUNC;
                cmd.out_last  = 1'b1;
                consume       = 1'b1;
              end
            end
            icns_pkg::PH_LITERAL: begin
              if (out_free) begin
                cmd.step_lit  = 1'b1;
                cmd.end_plane = lit_close;
                done          = lit_close && stat_i.last_plane;
                trunc         = stat_i.final_item && !done;
                if (stat_i.lit_room) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = icns_pkg::KIND_LIT;
                  if (done) begin
                    state_d = icns_pkg::ST_DONE;
                  end else if (trunc) begin
                    state_d = icns_pkg::ST_TRUNC;
                  end else begin
                    cmd.out_last = 1'b1;
                    consume      = 1'b1;
                  end
                end else begin
                  consume = 1'b1;
                  if (done || trunc) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.out_kind = done ? icns_pkg::KIND_DONE : icns_pkg::KIND_TRUNC;
                    cmd.stop     = trunc;
                  end
                end
              end
            end
            icns_pkg::PH_REPEAT: begin
              if (!stat_i.take_zero) begin
                cmd.rep_start = 1'b1;
                state_d       = icns_pkg::ST_REPEAT;
              end else if (out_free) begin
                cmd.rep_start = 1'b1;
                cmd.end_plane = 1'b1;
                done          = stat_i.last_plane;
                trunc         = stat_i.final_item && !done;
                consume       = 1'b1;
                if (done || trunc) begin
                  cmd.out_load = 1'b1;
                  cmd.out_last = 1'b1;
                  cmd.out_kind = done ? icns_pkg::KIND_DONE : icns_pkg::KIND_TRUNC;
                  cmd.stop     = trunc;
                end
              end
            end
            default: begin
              consume = 1'b1;
            end
          endcase
        end
      end
      icns_pkg::ST_REPEAT: begin
        if (out_free) begin
          cmd.rep_word  = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_kind  = icns_pkg::KIND_REP;
          cmd.end_plane = rep_close;
          done          = rep_close && stat_i.last_plane;
          trunc         = stat_i.final_item && !done;
          if (stat_i.rep_last) begin
            if (done) begin
              state_d = icns_pkg::ST_DONE;
            end else if (trunc) begin
              state_d = icns_pkg::ST_TRUNC;
            end else begin
              cmd.out_last = 1'b1;
              consume      = 1'b1;
              state_d      = icns_pkg::ST_RUN;
            end
          end
        end
      end
      icns_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = icns_pkg::KIND_DONE;
          cmd.out_last = 1'b1;
          consume      = 1'b1;
          state_d      = icns_pkg::ST_RUN;
        end
      end
      icns_pkg::ST_TRUNC: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = icns_pkg::KIND_TRUNC;
          cmd.out_last = 1'b1;
          cmd.stop     = 1'b1;
          consume      = 1'b1;
          state_d      = icns_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = icns_pkg::ST_RUN;
      end
    endcase

    // item register refills as the held item retires
    in_stall_o    = itm_v_q && !consume;
    cmd.load_item = in_valid_i && !in_stall_o;
    itm_v_d       = cmd.load_item ? 1'b1 : (consume ? 1'b0 : itm_v_q);
    ov_d          = cmd.out_load ? 1'b1 : (out_stall_i ? ov_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icns_pkg::ST_RUN;
      itm_v_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      itm_v_q <= itm_v_d;
      ov_q    <= ov_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = ov_q;

  `ASSERT_ALWAYS(a_busy_has_item, state_q == icns_pkg::ST_RUN || itm_v_q, "busy without item")
  `ASSERT_ALWAYS(a_load_when_free, !cmd.out_load || out_free, "output overwritten")
  `ASSERT_NEXT(a_done_retires, state_q == icns_pkg::ST_DONE && out_free, state_q == icns_pkg::ST_RUN && ov_q, "completion not given")
  `ASSERT_ALWAYS(a_one_step, $countones({cmd.step_code, cmd.step_lit, cmd.rep_start, cmd.rep_word}) <= 1, "two steps at once")

endmodule

>>> rtl/icns_rle_plane_decoder.sv
// top level of the icns run-length plane decoder
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------
//  input    | in        | in_valid_i / in_stall_o   | in_item_i  (in_item_t)
//  output   | out       | out_valid_o / out_stall_i | out_item_o (out_item_t)
//  config   | in        | psel penable pwrite pready | paddr pwdata prdata
//
//  code bytes and literal bytes are decoded one byte at a time, bytes after a stop are dropped
//  a repeat byte is sized first and then sent as words of up to 8 bytes
//  a completion or truncation status after data is sent as its own output item
//  a one-item input register and the output register part the two sides
//  reset clears decode state and loads pixel_count 1024 and plane_count 4
module icns_rle_plane_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  icns_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output icns_pkg::out_item_t          out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [icns_pkg::PADDR_W-1:0] paddr,
  input  logic [icns_pkg::DATA_W-1:0]  pwdata,
  output logic [icns_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  icns_pkg::cfg_t     cfg;
  icns_pkg::dp_cmd_t  cmd;
  icns_pkg::dp_stat_t stat;

  icns_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  icns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  icns_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule
